// ===== src/xsd_pkg.sv =====
// ----------------------------------------------------------------------------
// xsd_pkg
// Shared types, constants and the seed step for the shuffle draw unit.
// ----------------------------------------------------------------------------
package xsd_pkg;

    localparam int POOL_SIZE = 5;
    localparam int SEED_W    = 16;
    localparam int PICK_W    = 3;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int ENTRY_W   = (IDX_W > PICK_W) ? IDX_W : PICK_W;

    typedef logic [SEED_W-1:0]  seed_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [PICK_W-1:0]  pick_t;

    localparam seed_t SEED_RESET = 16'h5A3C;

    // xorshift16 step: <<7, >>9, <<8, all kept to 16 bits
    function automatic seed_t seed_advance(seed_t s);
        seed_t v;
        v = s ^ (s << 7);
        v = v ^ (v >> 9);
        v = v ^ (v << 8);
        return v;
    endfunction

endpackage

// ===== src/xsd_in_if.sv =====
// ----------------------------------------------------------------------------
// xsd_in_if
// Input channel: one mix value per transfer.
// ----------------------------------------------------------------------------
interface xsd_in_if;
    logic          valid;
    logic          ready;
    xsd_pkg::seed_t mix_value;

    modport source (output valid, output mix_value, input ready);
    modport sink   (input valid, input mix_value, output ready);
endinterface

// ===== src/xsd_out_if.sv =====
// ----------------------------------------------------------------------------
// xsd_out_if
// Result channel: three picks of the shuffled pool per transfer.
// ----------------------------------------------------------------------------
interface xsd_out_if;
    logic           valid;
    logic           ready;
    xsd_pkg::pick_t first_pick;
    logic [xsd_pkg::PICK_W-1:0] second_pick;
    logic [xsd_pkg::PICK_W-1:0] third_pick;

    modport source (output valid, output first_pick, output second_pick,
                    output third_pick, input ready);
    modport sink   (input valid, input first_pick, input second_pick,
                    input third_pick, output ready);
endinterface

// ===== src/xorshift_shuffle_draw_unit.sv =====
// ----------------------------------------------------------------------------
// xorshift_shuffle_draw_unit
// Seeded Fisher-Yates draw: three leading entries of a shuffled pool.
// ----------------------------------------------------------------------------
// Usage:
//   draw_in  (valid/ready) carries a 16-bit mix value, XORed into the kept
//            xorshift seed. draw_out (valid/ready) returns the entries at
//            positions zero, one and two of the pool after a Fisher-Yates
//            shuffle of 0..POOL_SIZE-1 driven by that seed.
//   Throughput: one item per cycle unless draw_out stalls. The seed
//   advances POOL_SIZE-1 xorshift steps per item through one combinational
//   path from the input register into the result register, and the seed
//   register closes that loop.
//   Stall: while draw_out is held, one more item is taken into the input
//   register, then draw_in.ready drops until the result is taken.
//   Reset: seed returns to 0x5A3C, both stages empty.
// ----------------------------------------------------------------------------
module xorshift_shuffle_draw_unit (
    input  logic      clk,
    input  logic      rst_n,
    xsd_in_if.sink    draw_in,
    xsd_out_if.source draw_out
);

    localparam int RecipShift = 20;
    localparam int RecipW     = RecipShift + 1;
    localparam int ProdW      = xsd_pkg::SEED_W + RecipW;

    logic                 s1_valid_reg;
    xsd_pkg::seed_t       mix_reg;
    xsd_pkg::seed_t       seed_reg;
    xsd_pkg::seed_t       seed_next;
    logic                 out_valid_reg;
    xsd_pkg::pick_t       first_reg;
    xsd_pkg::pick_t       second_reg;
    xsd_pkg::pick_t       third_reg;

    logic                 in_xfer;
    logic                 s1_advance;

    xsd_pkg::seed_t       seed_chain [xsd_pkg::POOL_SIZE];
    xsd_pkg::idx_t        swap_idx   [xsd_pkg::POOL_SIZE];
    xsd_pkg::entry_t      pool       [xsd_pkg::POOL_SIZE];
    xsd_pkg::entry_t      swap_tmp;

    assign s1_advance    = s1_valid_reg && (!out_valid_reg || draw_out.ready);
    assign draw_in.ready = !s1_valid_reg || s1_advance;
    assign in_xfer       = draw_in.valid && draw_in.ready;

    assign seed_chain[0] = seed_reg ^ mix_reg;
    assign swap_idx[0]   = '0;

    // one seed step and one small modulo per swap; modulo by reciprocal
    generate
        for (genvar k = 1; k < xsd_pkg::POOL_SIZE; k++) begin : g_step
            localparam int Modulus = xsd_pkg::POOL_SIZE - k + 1;
            localparam logic [RecipW-1:0] Recip =
                RecipW'(((2 ** RecipShift) + Modulus - 1) / Modulus);

            logic [ProdW-1:0] prod;
            xsd_pkg::seed_t   quot;
            xsd_pkg::seed_t   rem;

            assign seed_chain[k] = xsd_pkg::seed_advance(seed_chain[k-1]);
            assign prod = {{RecipW{1'b0}}, seed_chain[k]}
                        * {{xsd_pkg::SEED_W{1'b0}}, Recip};
            assign quot = prod[RecipShift+xsd_pkg::SEED_W-1:RecipShift];
            assign rem  = seed_chain[k] - 16'(quot * 16'(Modulus));
            assign swap_idx[k] = xsd_pkg::idx_t'(rem);
        end
    endgenerate

    assign seed_next = seed_chain[xsd_pkg::POOL_SIZE-1];

    always_comb
    begin
        swap_tmp = '0;
        for (int e = 0; e < xsd_pkg::POOL_SIZE; e++)
        begin
            pool[e] = xsd_pkg::entry_t'(e);
        end
        for (int k = 1; k < xsd_pkg::POOL_SIZE; k++)
        begin
            swap_tmp = pool[xsd_pkg::idx_t'(xsd_pkg::POOL_SIZE - k)];
            pool[xsd_pkg::idx_t'(xsd_pkg::POOL_SIZE - k)] = pool[swap_idx[k]];
            pool[swap_idx[k]] = swap_tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= xsd_pkg::SEED_RESET;
        end
        else
        begin
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (draw_out.ready)
                out_valid_reg <= 1'b0;

            if (s1_advance)
                seed_reg <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            mix_reg <= draw_in.mix_value;
        if (s1_advance)
        begin
            first_reg  <= pool[0][xsd_pkg::PICK_W-1:0];
            second_reg <= pool[1][xsd_pkg::PICK_W-1:0];
            third_reg  <= pool[2][xsd_pkg::PICK_W-1:0];
        end
    end

    assign draw_out.valid       = out_valid_reg;
    assign draw_out.first_pick  = first_reg;
    assign draw_out.second_pick = second_reg;
    assign draw_out.third_pick  = third_reg;

endmodule

// ===== src/xsd_checker.sv =====
// ----------------------------------------------------------------------------
// xsd_checker
// Port-level checks for the shuffle draw unit, bound into the draw unit module.
// ----------------------------------------------------------------------------
module xsd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [xsd_pkg::PICK_W-1:0] first_pick,
    input logic [xsd_pkg::PICK_W-1:0] second_pick,
    input logic [xsd_pkg::PICK_W-1:0] third_pick
);

    localparam bit NoAlias = (xsd_pkg::POOL_SIZE <= (1 << xsd_pkg::PICK_W));
    localparam logic [xsd_pkg::PICK_W-1:0] MaxPick =
        xsd_pkg::PICK_W'(NoAlias ? xsd_pkg::POOL_SIZE - 1 : 0);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_pick)
            && $stable(second_pick) && $stable(third_pick))
        else $error("result changed while stalled");

    // a permutation never repeats an entry
    a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && NoAlias |-> first_pick != second_pick
            && first_pick != third_pick && second_pick != third_pick)
        else $error("repeated pool entry in draw");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && NoAlias |-> first_pick <= MaxPick
            && second_pick <= MaxPick && third_pick <= MaxPick)
        else $error("pick outside pool");

endmodule

bind xorshift_shuffle_draw_unit xsd_checker u_xsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (draw_out.valid),
    .out_ready   (draw_out.ready),
    .first_pick  (draw_out.first_pick),
    .second_pick (draw_out.second_pick),
    .third_pick  (draw_out.third_pick)
);

// ===== sim/xsd_draw_checker.sv =====
// ----------------------------------------------------------------------------
// xsd_draw_checker
// Predicts and checks the picks of the shuffle draw unit.
// The checker watches both channels. For each mix value transfer it runs its
// own copy of the seed and the Fisher-Yates pass and queues the three picks.
// Each result transfer is checked field by field against the oldest entry in
// that queue.
// ----------------------------------------------------------------------------
module xsd_draw_checker (
    input  logic clk,
    input  logic rst_n,
    xsd_in_if    draw_in,
    xsd_out_if   draw_out,
    output int   mismatch_count,
    output int   draws_pending,
    output int   draws_checked,
    output int   zero_seed_draws
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        xsd_pkg::pick_t first;
        xsd_pkg::pick_t second;
        xsd_pkg::pick_t third;
    } picks_t;

    xsd_pkg::seed_t draw_seed;
    picks_t         picks_q[$];
    int             errors;
    int             checked;
    int             zero_seeds;

    // one xorshift16 step, written as explicit bit moves
    function automatic xsd_pkg::seed_t xs16_step(input xsd_pkg::seed_t s);
        xsd_pkg::seed_t t;
        t = s ^ {s[8:0], 7'b0};
        t = t ^ {9'b0, t[15:9]};
        t = t ^ {t[7:0], 8'b0};
        return t;
    endfunction

    // advances draw_seed and returns the three leading entries
    function automatic picks_t shuffle_picks(input xsd_pkg::seed_t mix);
        int     pool[xsd_pkg::POOL_SIZE];
        int     j;
        int     tmp;
        picks_t p;
        for (int k = 0; k < xsd_pkg::POOL_SIZE; k++)
            pool[k] = k;
        draw_seed = draw_seed ^ mix;
        for (int i = xsd_pkg::POOL_SIZE - 1; i > 0; i--)
        begin
            draw_seed = xs16_step(draw_seed);
            j = int'(draw_seed) % (i + 1);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        p.first  = pool[0][xsd_pkg::PICK_W-1:0];
        p.second = pool[1][xsd_pkg::PICK_W-1:0];
        p.third  = pool[2][xsd_pkg::PICK_W-1:0];
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        picks_t want;
        if (!rst_n)
        begin
            draw_seed  = xsd_pkg::SEED_RESET;
            picks_q.delete();
            errors     = 0;
            checked    = 0;
            zero_seeds = 0;
        end
        else
        begin
            // result side first: a result never belongs to a same-edge transfer
            if (draw_out.valid && draw_out.ready)
            begin
                if (picks_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result %0d/%0d/%0d with no draw pending", $realtime,
                                 draw_out.first_pick, draw_out.second_pick,
                                 draw_out.third_pick);
                end
                else
                begin
                    want = picks_q.pop_front();
                    checked++;
                    if (draw_out.first_pick !== want.first ||
                        draw_out.second_pick !== want.second ||
                        draw_out.third_pick !== want.third)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: draw %0d mismatch, expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, checked, want.first, want.second, want.third,
                                     draw_out.first_pick, draw_out.second_pick,
                                     draw_out.third_pick);
                    end
                end
            end
            if (draw_in.valid && draw_in.ready)
            begin
                if ((draw_seed ^ draw_in.mix_value) == '0)
                    zero_seeds++;
                picks_q.push_back(shuffle_picks(draw_in.mix_value));
            end
        end
        mismatch_count  <= errors;
        draws_pending   <= picks_q.size();
        draws_checked   <= checked;
        zero_seed_draws <= zero_seeds;
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the shuffle draw unit.
// A directed set (zero seed, all-ones and walking-one mix values) is followed
// by random mix values sent in bursts, while the result side stalls on its own
// changing pattern. The checker beside the block does the predicting.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_DRAWS = 1080;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    xsd_in_if  draw_in_ch();
    xsd_out_if draw_out_ch();

    int mismatch_count;
    int draws_pending;
    int draws_checked;
    int zero_seed_draws;
    int mix_sent;
    int burst_left;

    always #6 clk = ~clk;

    xorshift_shuffle_draw_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .draw_in  (draw_in_ch),
        .draw_out (draw_out_ch)
    );

    xsd_draw_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .draw_in         (draw_in_ch),
        .draw_out        (draw_out_ch),
        .mismatch_count  (mismatch_count),
        .draws_pending   (draws_pending),
        .draws_checked   (draws_checked),
        .zero_seed_draws (zero_seed_draws)
    );

    // one transfer; at the end of a burst valid may drop for a random gap
    task automatic send_mix(input xsd_pkg::seed_t value);
        int gap;
        draw_in_ch.valid     <= 1'b1;
        draw_in_ch.mix_value <= value;
        @(posedge clk);
        while (!draw_in_ch.ready)
            @(posedge clk);
        mix_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                draw_in_ch.valid     <= 1'b0;
                draw_in_ch.mix_value <= xsd_pkg::seed_t'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic xsd_pkg::seed_t random_mix();
        case ($urandom_range(0, 19))
            0, 1:    return '0;
            2:       return '1;
            3, 4:    return xsd_pkg::seed_t'(1) << $urandom_range(0, xsd_pkg::SEED_W - 1);
            5:       return ~(xsd_pkg::seed_t'(1) << $urandom_range(0, xsd_pkg::SEED_W - 1));
            default: return xsd_pkg::seed_t'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        rst_n                <= 1'b0;
        draw_in_ch.valid     <= 1'b0;
        draw_in_ch.mix_value <= '0;
        mix_sent   = 0;
        burst_left = 3;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // seed after reset XOR itself gives a zero seed, and zero mixes keep it
        send_mix(xsd_pkg::SEED_RESET);
        send_mix('0);
        send_mix('0);
        send_mix('1);
        send_mix(16'hAAAA);
        send_mix(16'h5555);
        for (int b = 0; b < xsd_pkg::SEED_W; b++)
            send_mix(xsd_pkg::seed_t'(1) << b);

        for (int n = 0; n < RANDOM_DRAWS; n++)
            send_mix(random_mix());
        draw_in_ch.valid <= 1'b0;
        @(posedge clk);

        while (draws_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d mix values and checked %0d draws (%0d from an all-zero seed).",
                 mix_sent, draws_checked, zero_seed_draws);
        $display("Sender ran in bursts with gaps; receiver cycled open, random and held stalls.");
        if (mismatch_count == 0 && draws_pending == 0)
            $display("xorshift_shuffle_draw_unit test passed");
        else
            $display("xorshift_shuffle_draw_unit test failed");
        $finish;
    end

    initial
    begin : result_stall
        rx_mode_t mode;
        int       span;
        int       hold;
        draw_out_ch.ready <= 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    RX_OPEN:   draw_out_ch.ready <= 1'b1;
                    RX_COIN:   draw_out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: draw_out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        // a single ready cycle, then a long hold
                        if (hold == 0)
                        begin
                            draw_out_ch.ready <= 1'b1;
                            hold = $urandom_range(3, 15);
                        end
                        else
                        begin
                            draw_out_ch.ready <= 1'b0;
                            hold--;
                        end
                    end
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("xorshift_shuffle_draw_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/xsd_pkg.sv
src/xsd_in_if.sv
src/xsd_out_if.sv
src/xorshift_shuffle_draw_unit.sv
src/xsd_checker.sv
sim/xsd_draw_checker.sv
sim/testbench.sv
